[src/mbx_pkg.sv]
// Shared constants, types and helpers for the inter-core mailbox grid.
package mbx_pkg;

   // Grid geometry
   localparam int RING_DEPTH    = 64;
   localparam int CORE_COUNT    = 4;
   localparam int PAYLOAD_WIDTH = 64;

   localparam int RING_COUNT = CORE_COUNT * CORE_COUNT;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int OCC_W      = PTR_W + 1;
   localparam int CORE_W     = $clog2(CORE_COUNT);
   localparam int RING_W     = $clog2(RING_COUNT);
   localparam int STORE_DEPTH = RING_COUNT * RING_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Request and response field widths
   localparam int MODE_W   = 3;
   localparam int IDX_W    = 3;
   localparam int WORD_W   = 64;
   localparam int VALUE_W  = 32;
   localparam int WAKE_W   = 4;

   localparam int REQ_BITS     = MODE_W + IDX_W + IDX_W + WORD_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS     = 1 + WORD_W + VALUE_W + WAKE_W;
   localparam int RSP_TDATA_W  = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH    = 3'd0,
      MODE_POP     = 3'd1,
      MODE_PEEK    = 3'd2,
      MODE_COUNT   = 3'd3,
      MODE_WAKE_EN = 3'd4,
      MODE_SENT    = 3'd5
   } mode_type;

   // Updates applied to the ring table for the selected ring / core
   typedef struct packed {
      logic head_adv;
      logic tail_adv;
      logic wake_set;
      logic sent_inc;
   } ring_upd_type;

   // Ring table contents for the selected ring / core
   typedef struct packed {
      logic [PTR_W-1:0]   head;
      logic [PTR_W-1:0]   tail;
      logic               wake_en;
      logic [VALUE_W-1:0] sent_total;
   } ring_view_type;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
      logic [OCC_W-1:0] nx;
      nx = OCC_W'(p) + OCC_W'(1);
      ptr_advance = (nx >= OCC_W'(RING_DEPTH)) ? '0 : nx[PTR_W-1:0];
   endfunction

endpackage

[src/mbx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mbx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/mbx_ring_state.sv]
// Ring pointer table, per-core wake enables and per-core sent totals.
module mbx_ring_state (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mbx_pkg::RING_W-1:0]  ring_sel,
   input  logic [mbx_pkg::CORE_W-1:0]  core_sel,
   input  mbx_pkg::ring_upd_type       upd,
   output mbx_pkg::ring_view_type      view
);
   import mbx_pkg::*;

   logic [PTR_W-1:0]   head_ff    [RING_COUNT];
   logic [PTR_W-1:0]   tail_ff    [RING_COUNT];
   logic               wake_en_ff [CORE_COUNT];
   // sum over all source rings toward one core, kept as one running total
   logic [VALUE_W-1:0] sent_ff    [CORE_COUNT];

   always_comb begin
      view.head       = head_ff[ring_sel];
      view.tail       = tail_ff[ring_sel];
      view.wake_en    = wake_en_ff[core_sel];
      view.sent_total = sent_ff[core_sel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_COUNT; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
         for (int i = 0; i < CORE_COUNT; i++) begin
            wake_en_ff[i] <= 1'b0;
            sent_ff[i]    <= '0;
         end
      end else begin
         if (upd.head_adv) begin
            head_ff[ring_sel] <= ptr_advance(head_ff[ring_sel]);
         end
         if (upd.tail_adv) begin
            tail_ff[ring_sel] <= ptr_advance(tail_ff[ring_sel]);
         end
         if (upd.wake_set) begin
            wake_en_ff[core_sel] <= 1'b1;
         end
         if (upd.sent_inc) begin
            sent_ff[core_sel] <= sent_ff[core_sel] + VALUE_W'(1);
         end
      end
   end

endmodule

[src/inter_core_mailbox_fifo_grid.sv]
// Top level of the inter-core mailbox grid: request sequencer and result register.
// Sequence: an accepted request passes through the ring step (ST_EXEC) and the result stage
//   (ST_FINISH), which waits until the previous result is claimed; the message RAM read sits
//   between the ring decision and the result load, and requests run one at a time.
// Reset: synchronous, active high; clears ring pointers, wake enables, sent totals
//   and the handshake state. The message RAM is not cleared and needs no clearing pass.
module inter_core_mailbox_fifo_grid (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: mode[2:0], src_core[5:3], dst_core[8:6], payload_in[72:9], zero pad
   input  logic [mbx_pkg::REQ_TDATA_W-1:0] req_tdata,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: ok[0], payload_out[64:1], value_out[96:65], wake_mask[100:97], zero pad
   output logic [mbx_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mbx_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] payload;
      logic [IDX_W-1:0]  dst;
      logic [IDX_W-1:0]  src;
      logic [MODE_W-1:0] mode;
   } req_type;

   typedef struct packed {
      logic [WAKE_W-1:0]  wake;
      logic [VALUE_W-1:0] value;
      logic [WORD_W-1:0]  payload;
      logic               ok;
   } rsp_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // decision of the ring step, held until the RAM data is back
   logic               ok_ff, ok_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [WAKE_W-1:0]  wake_ff, wake_in;
   logic               rd_hit_ff, rd_hit_in;

   // ring decode of the held request
   logic                  ring_ok, dst_ok;
   logic [CORE_W-1:0]     src_idx, dst_idx;
   logic [RING_W-1:0]     ring_sel;
   ring_upd_type          upd;
   ring_view_type         view;
   logic                  ring_full, ring_empty;
   logic [OCC_W-1:0]      occupancy;

   // message RAM
   logic                     ram_wr_en, ram_rd_en;
   logic [STORE_AW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [PAYLOAD_WIDTH-1:0] ram_rd_data;

   logic rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign ring_ok  = (req_ff.src < IDX_W'(CORE_COUNT)) && (req_ff.dst < IDX_W'(CORE_COUNT));
   assign dst_ok   = (req_ff.dst < IDX_W'(CORE_COUNT));
   assign src_idx  = req_ff.src[CORE_W-1:0];
   assign dst_idx  = req_ff.dst[CORE_W-1:0];
   assign ring_sel = RING_W'(src_idx) * RING_W'(CORE_COUNT) + RING_W'(dst_idx);

   assign ring_full  = (ptr_advance(view.head) == view.tail);
   assign ring_empty = (view.head == view.tail);
   assign occupancy  = (view.head >= view.tail)
                     ? (OCC_W'(view.head) - OCC_W'(view.tail))
                     : (OCC_W'(view.head) + OCC_W'(RING_DEPTH) - OCC_W'(view.tail));

   // slot address = ring * depth + pointer
   assign ram_wr_addr = STORE_AW'(ring_sel) * STORE_AW'(RING_DEPTH) + STORE_AW'(view.head);
   assign ram_rd_addr = STORE_AW'(ring_sel) * STORE_AW'(RING_DEPTH) + STORE_AW'(view.tail);

   mbx_ring_state u_ring_state (
      .clock    (clock),
      .reset    (reset),
      .ring_sel (ring_sel),
      .core_sel (dst_idx),
      .upd      (upd),
      .view     (view)
   );

   mbx_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_ff.payload[PAYLOAD_WIDTH-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Ring step: decide the outcome and update pointers, counters and the RAM.
   always_comb begin
      upd       = '0;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      ok_in     = ok_ff;
      value_in  = value_ff;
      wake_in   = wake_ff;
      rd_hit_in = rd_hit_ff;
      if (state_ff == ST_EXEC) begin
         ok_in     = 1'b0;
         value_in  = '0;
         wake_in   = '0;
         rd_hit_in = 1'b0;
         case (req_ff.mode)
            MODE_PUSH: begin
               if (ring_ok && !ring_full) begin
                  ok_in        = 1'b1;
                  ram_wr_en    = 1'b1;
                  upd.head_adv = 1'b1;
                  if (view.wake_en) begin
                     upd.sent_inc = 1'b1;
                     // only cores below four can show up in the mask
                     if (req_ff.dst < IDX_W'(WAKE_W)) begin
                        wake_in = WAKE_W'(1) << req_ff.dst;
                     end
                  end
               end
            end
            MODE_POP, MODE_PEEK: begin
               if (ring_ok && !ring_empty) begin
                  ok_in        = 1'b1;
                  ram_rd_en    = 1'b1;
                  rd_hit_in    = 1'b1;
                  upd.tail_adv = (req_ff.mode == MODE_POP);
               end
            end
            MODE_COUNT: begin
               if (ring_ok) begin
                  ok_in    = 1'b1;
                  value_in = VALUE_W'(occupancy);
               end
            end
            MODE_WAKE_EN: begin
               if (dst_ok) begin
                  ok_in        = 1'b1;
                  upd.wake_set = 1'b1;
               end
            end
            MODE_SENT: begin
               if (dst_ok) begin
                  ok_in    = 1'b1;
                  value_in = view.sent_total;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   // Sequencer and result register.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               req_in   = req_type'(req_tdata[REQ_BITS-1:0]);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait here while the previous result is still unclaimed
            if (rsp_free) begin
               rsp_in.ok      = ok_ff;
               rsp_in.payload = rd_hit_ff ? WORD_W'(ram_rd_data) : '0;
               rsp_in.value   = value_ff;
               rsp_in.wake    = wake_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      ok_ff     <= ok_in;
      value_ff  <= value_in;
      wake_ff   <= wake_in;
      rd_hit_ff <= rd_hit_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter the ring step");

   a_exec_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_FINISH))
      else $error("ring step not followed by result stage");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.ok) |->
      (rsp_ff.payload == '0 && rsp_ff.value == '0 && rsp_ff.wake == '0))
      else $error("failed request carries nonzero result fields");

   a_wake_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($onehot0(rsp_ff.wake) &&
      (rsp_ff.wake == '0 || rsp_ff.ok)))
      else $error("wake mask not one-hot or raised on a failed request");
`endif

endmodule

[sim/mbx_checker.sv]
// Mailbox grid checker: request/response monitor, ring-state predictor and field compare.
`timescale 1ns / 100ps

module mbx_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mbx_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mbx_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              mismatches,
   output int                              pending
);
   import mbx_pkg::*;

   // request field offsets
   localparam int SRC_LSB  = MODE_W;
   localparam int DST_LSB  = MODE_W + IDX_W;
   localparam int WORD_LSB = MODE_W + 2 * IDX_W;
   // response field offsets
   localparam int VALUE_LSB = 1 + WORD_W;
   localparam int WAKE_LSB  = 1 + WORD_W + VALUE_W;

   typedef struct packed {
      logic               ok;
      logic [WORD_W-1:0]  word;
      logic [VALUE_W-1:0] value;
      logic [WAKE_W-1:0]  wake;
   } ring_answer_type;

   // shadow of the grid
   logic [PAYLOAD_WIDTH-1:0] ring_words [RING_COUNT][RING_DEPTH];
   logic [PTR_W-1:0]         ring_head  [RING_COUNT];
   logic [PTR_W-1:0]         ring_tail  [RING_COUNT];
   logic                     core_wake  [CORE_COUNT];
   logic [VALUE_W-1:0]       pair_sent  [RING_COUNT];

   ring_answer_type awaited_answers [$];
   int              fail_count = 0;

   assign mismatches = fail_count;

   function automatic ring_answer_type mailbox_answer(input logic [MODE_W-1:0] mode,
                                                      input logic [IDX_W-1:0]  src,
                                                      input logic [IDX_W-1:0]  dst,
                                                      input logic [WORD_W-1:0] word);
      ring_answer_type  ans;
      logic             dst_ok;
      logic             pair_ok;
      int               r;
      int               s;
      logic [PTR_W-1:0] h;
      logic [PTR_W-1:0] t;
      logic [PTR_W-1:0] nx;
      ans     = '0;
      dst_ok  = dst < CORE_COUNT;
      pair_ok = dst_ok && (src < CORE_COUNT);
      r       = pair_ok ? int'(src) * CORE_COUNT + int'(dst) : 0;
      h       = ring_head[r];
      t       = ring_tail[r];
      nx      = (h == PTR_W'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
      case (mode)
         MODE_PUSH: if (pair_ok && nx != t) begin
            ring_words[r][h] = word[PAYLOAD_WIDTH-1:0];
            ring_head[r]     = nx;
            ans.ok           = 1'b1;
            if (core_wake[dst[CORE_W-1:0]]) begin
               pair_sent[r] = pair_sent[r] + 1'b1;
               ans.wake     = WAKE_W'(1) << dst;
            end
         end
         MODE_POP, MODE_PEEK: if (pair_ok && t != h) begin
            ans.ok   = 1'b1;
            ans.word = WORD_W'(ring_words[r][t]);
            if (mode == MODE_POP)
               ring_tail[r] = (t == PTR_W'(RING_DEPTH - 1)) ? '0 : t + 1'b1;
         end
         MODE_COUNT: if (pair_ok) begin
            ans.ok    = 1'b1;
            ans.value = (h >= t) ? VALUE_W'(h) - VALUE_W'(t)
                                 : VALUE_W'(h) + VALUE_W'(RING_DEPTH) - VALUE_W'(t);
         end
         MODE_WAKE_EN: if (dst_ok) begin
            core_wake[dst[CORE_W-1:0]] = 1'b1;
            ans.ok = 1'b1;
         end
         MODE_SENT: if (dst_ok) begin
            ans.ok = 1'b1;
            for (s = 0; s < CORE_COUNT; s++)
               ans.value = ans.value + pair_sent[s * CORE_COUNT + int'(dst)];
         end
         default: ;
      endcase
      return ans;
   endfunction

   task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      ring_answer_type seen;
      ring_answer_type want;
      int              i;
      if (reset) begin
         for (i = 0; i < RING_COUNT; i++) begin
            ring_head[i] = '0;
            ring_tail[i] = '0;
            pair_sent[i] = '0;
         end
         for (i = 0; i < CORE_COUNT; i++)
            core_wake[i] = 1'b0;
         awaited_answers.delete();
      end else begin
         if (req_tvalid && req_tready)
            awaited_answers.push_back(mailbox_answer(req_tdata[MODE_W-1:0],
                                                     req_tdata[SRC_LSB +: IDX_W],
                                                     req_tdata[DST_LSB +: IDX_W],
                                                     req_tdata[WORD_LSB +: WORD_W]));
         if (rsp_tvalid && rsp_tready) begin
            seen.ok    = rsp_tdata[0];
            seen.word  = rsp_tdata[1 +: WORD_W];
            seen.value = rsp_tdata[VALUE_LSB +: VALUE_W];
            seen.wake  = rsp_tdata[WAKE_LSB +: WAKE_W];
            if (awaited_answers.size() == 0) begin
               fail_count++;
               $display("%0t: response with none expected, expected nothing, got %h",
                        $time, rsp_tdata);
            end else begin
               want = awaited_answers.pop_front();
               compare_field("ok", WORD_W'(want.ok), WORD_W'(seen.ok));
               compare_field("payload_out", want.word, seen.word);
               compare_field("value_out", WORD_W'(want.value), WORD_W'(seen.value));
               compare_field("wake_mask", WORD_W'(want.wake), WORD_W'(seen.wake));
            end
         end
      end
      pending <= awaited_answers.size();
   end

endmodule

[sim/tb.sv]
// Testbench top for the mailbox grid: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 100ps

module tb;
   import mbx_pkg::*;

   // modes the block must refuse
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   localparam int RANDOM_REQUESTS = 1250;
   localparam int WATCHDOG_LIMIT  = 4000;  // idle cycles; the longest legal lull is the long response hold
   localparam int PRESSURE_START  = 2000;  // cycle at which the long response hold begins
   localparam int PRESSURE_HOLD   = 600;
   localparam int DRAIN_CYCLES    = 12;    // margin after the last awaited response

   localparam logic [WORD_W-1:0] WORD_ONES = '1;
   localparam logic [WORD_W-1:0] WORD_ALT  = 64'haaaa_5555_aaaa_5555;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatches;
   int pending;
   int idle_cycles   = 0;
   int cycle_count   = 0;
   bit req_lulls     = 1'b1;   // sender inserts gaps while set
   bit rsp_lulls     = 1'b1;   // receiver stalls while set
   bit pressure_done = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   inter_core_mailbox_fifo_grid dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mbx_checker mailbox_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Gap length: mostly none or short, now and then a long one.
   function automatic int idle_span(input bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // Payloads lean on the extremes now and then.
   function automatic logic [WORD_W-1:0] rand_word();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return WORD_ONES;
      return {$urandom, $urandom};
   endfunction

   // Core index: mostly in range, sometimes anything the field can carry.
   function automatic logic [IDX_W-1:0] rand_core();
      if ($urandom_range(0, 9) == 0)
         return IDX_W'($urandom_range(0, 7));
      return IDX_W'($urandom_range(0, CORE_COUNT - 1));
   endfunction

   // Drive one request at the falling edge and hold it until accepted.
   // Valid stays high between back-to-back requests.
   task automatic issue(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] src,
                        input logic [IDX_W-1:0] dst, input logic [WORD_W-1:0] word);
      int lull;
      lull = idle_span(req_lulls);
      @(negedge clock);
      if (lull > 0) begin
         req_tvalid <= 1'b0;
         repeat (lull) @(negedge clock);
      end
      req_tdata  <= REQ_TDATA_W'({word, dst, src, mode});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // One request with a random mode, weighted toward ring traffic.
   task automatic random_request();
      int                roll;
      logic [MODE_W-1:0] mode;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         mode = MODE_PUSH;
      else if (roll < 50)
         mode = MODE_POP;
      else if (roll < 60)
         mode = MODE_PEEK;
      else if (roll < 70)
         mode = MODE_COUNT;
      else if (roll < 72)
         mode = MODE_WAKE_EN;
      else if (roll < 84)
         mode = MODE_SENT;
      else if (roll < 92)
         mode = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
      else
         mode = MODE_W'($urandom_range(0, 7));
      issue(mode, rand_core(), rand_core(), rand_word());
   endtask

   initial begin : stimulus
      int               kind;
      int               burst;
      int               sent;
      int               i;
      logic [IDX_W-1:0] src;
      logic [IDX_W-1:0] dst;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: empty ring, extremes of the payload, wake path, bad indexes, unused modes.
      issue(MODE_COUNT, 0, 0, '0);
      issue(MODE_POP, 0, 0, '0);
      issue(MODE_PEEK, 0, 0, '0);
      issue(MODE_PUSH, 0, 0, WORD_ONES);
      issue(MODE_PUSH, 0, 0, '0);
      issue(MODE_COUNT, 0, 0, WORD_ONES);
      issue(MODE_PEEK, 0, 0, '0);
      issue(MODE_POP, 0, 0, '0);
      issue(MODE_POP, 0, 0, '0);
      issue(MODE_PUSH, 2, 3, WORD_ALT);            // core 3 not yet awake
      issue(MODE_WAKE_EN, 7, 3, '0);               // src ignored here
      issue(MODE_PUSH, 2, 3, ~WORD_ALT);           // now raises wake for core 3
      issue(MODE_PUSH, 3, 3, WORD_ALT);            // diagonal ring
      issue(MODE_COUNT, 3, 3, '0);
      issue(MODE_SENT, 6, 3, '0);
      issue(MODE_SENT, 0, 0, '0);
      issue(MODE_PUSH, 4, 0, WORD_ONES);           // bad src
      issue(MODE_POP, 0, 7, '0);                   // bad dst
      issue(MODE_WAKE_EN, 0, 4, '0);               // bad core for wake enable
      issue(MODE_SENT, 0, 7, '0);                  // bad core for sent total
      issue(MODE_UNUSED_LO, 1, 1, WORD_ONES);
      issue(MODE_UNUSED_HI, 1, 1, WORD_ONES);
      issue(MODE_PUSH, 1, 2, WORD_ALT);
      issue(MODE_POP, 1, 2, '0);

      // Random: bursts that fill or drain one ring (so full and empty rings come up often),
      // mixed with scattered traffic. Sender gaps switch on and off per burst.
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         kind      = $urandom_range(0, 9);
         req_lulls = $urandom_range(0, 3) != 0;
         src       = IDX_W'($urandom_range(0, CORE_COUNT - 1));
         dst       = IDX_W'($urandom_range(0, CORE_COUNT - 1));
         if (kind < 3) begin
            burst = $urandom_range(30, 70);
            for (i = 0; i < burst; i++) begin
               if ($urandom_range(0, 9) == 0)
                  issue(MODE_COUNT, src, dst, rand_word());
               else
                  issue(MODE_PUSH, src, dst, rand_word());
            end
         end else if (kind < 5) begin
            burst = $urandom_range(30, 70);
            for (i = 0; i < burst; i++) begin
               case ($urandom_range(0, 19))
                  0:              issue(MODE_COUNT, src, dst, rand_word());
                  1, 2, 3, 4:     issue(MODE_PEEK, src, dst, rand_word());
                  default:        issue(MODE_POP, src, dst, rand_word());
               endcase
            end
         end else begin
            burst = 20;
            for (i = 0; i < burst; i++)
               random_request();
         end
         sent += burst;
      end
      @(negedge clock) req_tvalid <= 1'b0;

      // Let the checker see the last request, then wait for every response.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Response side: ready with random lulls, stretches with none, and one long hold
   // while requests keep coming so the block backs up into req_tready.
   initial begin : rsp_ready_gen
      int lull;
      int busy_for;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_lulls = !rsp_lulls;
         lull = idle_span(rsp_lulls);
         if (!pressure_done && cycle_count >= PRESSURE_START) begin
            lull          = PRESSURE_HOLD;
            pressure_done = 1'b1;
         end
         if (lull > 0) begin
            rsp_tready <= 1'b0;
            repeat (lull) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         busy_for = $urandom_range(1, 6);
         repeat (busy_for) @(negedge clock);
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
